>>> rtl/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Shared widths, codes and controller/datapath bundles of the encoder speed
// meter.
// ----------------------------------------------------------------------------
`default_nettype none

package esm_pkg;

  // Default values for the top-level parameters
  localparam int NUM_CHANNELS_DEF    = 2;
  localparam int MIN_INTERVAL_DEF    = 10;
  localparam int MAX_INTERVAL_DEF    = 2000;

  // Field widths
  localparam int OP_W       = 2;
  localparam int CNT_W      = 32;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SPEED_W    = 32;
  localparam int IVL_W      = 11;
  localparam int ACT_W      = 2;
  localparam int PPR_W      = 24;
  localparam int SPAN_W     = 31;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Channels that have their own configuration registers
  localparam int CFG_CHANNELS = 2;

  // Wrap-corrected delta, with headroom for the span add and subtract
  localparam int DELTA_W  = CNT_W + 2;
  // Magnitude of the corrected delta is at most 2^31
  localparam int MAG_W    = 32;
  // 60000 = 60 s/min * 1000 ms/s
  localparam int RPM_SCALE_W = 16;
  localparam logic [RPM_SCALE_W-1:0] RPM_SCALE = 16'd60000;
  localparam int NUM_W    = MAG_W + RPM_SCALE_W;
  // Quotient bits, and the left shift of the numerator (Q16.8 ppr to Q16.16)
  localparam int QUOT_W      = 32;
  localparam int FRAC_SHIFT  = 24;
  localparam int PRE_SHIFT   = QUOT_W - FRAC_SHIFT;
  localparam int STEP_W      = $clog2(QUOT_W);

  localparam logic [QUOT_W-1:0]  SPEED_SAT_MAG = 32'h8000_0000;
  localparam logic [SPEED_W-1:0] SPEED_MAX_POS = 32'h7FFF_FFFF;

  // Opcodes
  localparam logic [OP_W-1:0] OP_MEASURE    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESYNC     = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SPEED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BASELINE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR_CH0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPR_CH1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_CH0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_CH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_CH0  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_CH1  = 3'd6;

  // Configuration reset values
  localparam logic [ACT_W-1:0]  ACTIVE_RST = 2'd2;
  localparam logic [PPR_W-1:0]  PPR_RST    = 24'd256;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 31'd65536;
  localparam logic [DIR_W-1:0]  DIR_RST    = 2'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic                capture;
    logic                clear_valid;
    logic                store_base;
    logic                load_delta;
    logic                wrap_hi;
    logic                wrap_lo;
    logic                take_mag;
    logic                mult;
    logic                div_init;
    logic                div_step;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                load_out;
  } esm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic            bad;
    logic [OP_W-1:0] op;
    logic            base_valid;
    logic            dt_ok;
    logic            div_last;
  } esm_stat_t;

endpackage

`default_nettype wire

>>> rtl/esm_if.sv
// ----------------------------------------------------------------------------
// esm_if
// Request, result and configuration channels of the encoder speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

interface esm_in_if;
  logic                             valid;
  logic                             ready;
  logic [esm_pkg::OP_W-1:0]         opcode;
  logic                             channel;
  logic signed [esm_pkg::CNT_W-1:0] encoder_count;
  logic [esm_pkg::TIME_W-1:0]       now_ms;

  modport source(output valid, opcode, channel, encoder_count, now_ms, input ready);
  modport sink(input valid, opcode, channel, encoder_count, now_ms, output ready);
endinterface

interface esm_out_if;
  logic                               valid;
  logic                               ready;
  logic [esm_pkg::STATUS_W-1:0]       status;
  logic signed [esm_pkg::SPEED_W-1:0] speed_rpm;
  logic [esm_pkg::IVL_W-1:0]          interval_ms;

  modport source(output valid, status, speed_rpm, interval_ms, input ready);
  modport sink(input valid, status, speed_rpm, interval_ms, output ready);
endinterface

interface esm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [esm_pkg::CFG_IDX_W-1:0]   index;
  logic [esm_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/esm_ctrl.sv
// ----------------------------------------------------------------------------
// esm_ctrl
// Sequencer of the speed meter: classifies a request, steps the datapath
// through wrap correction, scaling and the bit-serial divide, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire esm_pkg::esm_stat_t stat,
  output esm_pkg::esm_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOOK     = 4'd1;
  localparam logic [3:0] S_WRAP_HI  = 4'd2;
  localparam logic [3:0] S_WRAP_LO  = 4'd3;
  localparam logic [3:0] S_MAG      = 4'd4;
  localparam logic [3:0] S_MULT     = 4'd5;
  localparam logic [3:0] S_DIV_INIT = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.set_status = 1'b1;
        state_next     = S_FINISH;
        if (stat.bad) begin
          cmd.status_code = esm_pkg::ST_BAD;
        end else if (stat.op == esm_pkg::OP_INVALIDATE) begin
          cmd.clear_valid = 1'b1;
          cmd.status_code = esm_pkg::ST_BASELINE;
        end else if (stat.op == esm_pkg::OP_RESYNC || !stat.base_valid) begin
          cmd.store_base  = 1'b1;
          cmd.status_code = esm_pkg::ST_BASELINE;
        end else if (!stat.dt_ok) begin
          cmd.store_base  = 1'b1;
          cmd.status_code = esm_pkg::ST_RANGE;
        end else begin
          cmd.store_base  = 1'b1;
          cmd.load_delta  = 1'b1;
          cmd.status_code = esm_pkg::ST_SPEED;
          state_next      = S_WRAP_HI;
        end
      end
      S_WRAP_HI: begin
        cmd.wrap_hi = 1'b1;
        state_next  = S_WRAP_LO;
      end
      S_WRAP_LO: begin
        cmd.wrap_lo = 1'b1;
        state_next  = S_MAG;
      end
      S_MAG: begin
        cmd.take_mag = 1'b1;
        state_next   = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hand the result over once the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK))
    else $error("accepted request did not advance to classification");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_div_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_last) |=> (state == S_FINISH))
    else $error("divide did not end after its last step");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !item_ready)
    else $error("request channel ready during divide");

endmodule

`default_nettype wire

>>> rtl/esm_datapath.sv
// ----------------------------------------------------------------------------
// esm_datapath
// Configuration registers, per-channel baselines, wrap correction, scaling
// multipliers, a restoring divider one quotient bit per cycle, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_datapath #(
  parameter int NUM_CHANNELS    = esm_pkg::NUM_CHANNELS_DEF,
  parameter int MIN_INTERVAL_MS = esm_pkg::MIN_INTERVAL_DEF,
  parameter int MAX_INTERVAL_MS = esm_pkg::MAX_INTERVAL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [esm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [esm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Request payload
  input  wire logic [esm_pkg::OP_W-1:0]          opcode,
  input  wire logic                              channel,
  input  wire logic signed [esm_pkg::CNT_W-1:0]  encoder_count,
  input  wire logic [esm_pkg::TIME_W-1:0]        now_ms,
  // Result payload
  output logic [esm_pkg::STATUS_W-1:0]           status,
  output logic signed [esm_pkg::SPEED_W-1:0]     speed_rpm,
  output logic [esm_pkg::IVL_W-1:0]              interval_ms,
  // Controller link
  input  wire esm_pkg::esm_cmd_t                 cmd,
  output esm_pkg::esm_stat_t                     stat
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DT_W     = $clog2(MAX_INTERVAL_MS + 1);
  localparam int DEN_W    = DT_W + esm_pkg::PPR_W;
  localparam int HI_W     = esm_pkg::NUM_W - esm_pkg::PRE_SHIFT;

  // Configuration registers
  logic [esm_pkg::ACT_W-1:0]  active_q;
  logic [esm_pkg::PPR_W-1:0]  ppr_q  [esm_pkg::CFG_CHANNELS];
  logic [esm_pkg::SPAN_W-1:0] span_q [esm_pkg::CFG_CHANNELS];
  logic [esm_pkg::DIR_W-1:0]  dir_q  [esm_pkg::CFG_CHANNELS];

  // Request registers
  logic [esm_pkg::OP_W-1:0]   op_q;
  logic                       ch_q;
  logic [esm_pkg::CNT_W-1:0]  cnt_q;
  logic [esm_pkg::TIME_W-1:0] now_q;
  logic [CH_IDX_W-1:0]        idx;

  // Per-channel baseline
  logic [esm_pkg::CNT_W-1:0]  last_count [NUM_CHANNELS];
  logic [esm_pkg::TIME_W-1:0] last_time  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    base_valid;

  // Arithmetic registers
  logic [DT_W-1:0]                     dt;
  logic signed [esm_pkg::DELTA_W-1:0]  delta;
  logic                                neg;
  logic [esm_pkg::MAG_W-1:0]           mag;
  logic [DEN_W-1:0]                    den;
  logic [esm_pkg::NUM_W-1:0]           num;
  logic                                sat;
  logic [DEN_W-1:0]                    rem;
  logic [esm_pkg::QUOT_W-1:0]          low_bits;
  logic [esm_pkg::QUOT_W-1:0]          quot;
  logic [esm_pkg::STEP_W-1:0]          step_cnt;
  logic [esm_pkg::STATUS_W-1:0]        res_status;

  // Combinational terms
  logic [esm_pkg::TIME_W-1:0]          dt_full;
  logic [esm_pkg::CNT_W-1:0]           raw_delta;
  logic signed [esm_pkg::DELTA_W-1:0]  span_s;
  logic signed [esm_pkg::DELTA_W-1:0]  half_s;
  logic signed [esm_pkg::DELTA_W-1:0]  neg_delta;
  logic [esm_pkg::PPR_W-1:0]           ppr_eff;
  logic [DEN_W:0]                      trial;
  logic [DEN_W:0]                      trial_diff;
  logic                                qbit;
  logic [esm_pkg::QUOT_W-1:0]          mag_fin;
  logic                                neg_fin;
  logic [esm_pkg::DIR_W-1:0]           dir_sel;
  logic [esm_pkg::SPEED_W-1:0]         speed_val;

  assign idx = CH_IDX_W'(ch_q);

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      active_q <= esm_pkg::ACTIVE_RST;
      for (int i = 0; i < esm_pkg::CFG_CHANNELS; i++) begin
        ppr_q[i]  <= esm_pkg::PPR_RST;
        span_q[i] <= esm_pkg::SPAN_RST;
        dir_q[i]  <= esm_pkg::DIR_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        esm_pkg::REG_ACTIVE:   active_q  <= cfg_data[esm_pkg::ACT_W-1:0];
        esm_pkg::REG_PPR_CH0:  ppr_q[0]  <= cfg_data[esm_pkg::PPR_W-1:0];
        esm_pkg::REG_PPR_CH1:  ppr_q[1]  <= cfg_data[esm_pkg::PPR_W-1:0];
        esm_pkg::REG_SPAN_CH0: span_q[0] <= cfg_data[esm_pkg::SPAN_W-1:0];
        esm_pkg::REG_SPAN_CH1: span_q[1] <= cfg_data[esm_pkg::SPAN_W-1:0];
        esm_pkg::REG_DIR_CH0:  dir_q[0]  <= cfg_data[esm_pkg::DIR_W-1:0];
        esm_pkg::REG_DIR_CH1:  dir_q[1]  <= cfg_data[esm_pkg::DIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      ch_q  <= channel;
      cnt_q <= encoder_count;
      now_q <= now_ms;
    end
  end

  // Classification terms
  assign dt_full   = now_q - last_time[idx];
  assign raw_delta = cnt_q - last_count[idx];

  assign stat.bad = ({1'b0, ch_q} >= active_q)
                 || ({31'b0, ch_q} >= 32'(NUM_CHANNELS))
                 || (op_q == esm_pkg::OP_RESERVED);
  assign stat.op         = op_q;
  assign stat.base_valid = base_valid[idx];
  assign stat.dt_ok      = (dt_full >= 32'(MIN_INTERVAL_MS))
                        && (dt_full <= 32'(MAX_INTERVAL_MS));
  assign stat.div_last   = (step_cnt == esm_pkg::STEP_W'(esm_pkg::QUOT_W - 1));

  // Baseline store and invalidate
  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid <= '0;
    end else if (cmd.clear_valid) begin
      base_valid[idx] <= 1'b0;
    end else if (cmd.store_base) begin
      base_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_base) begin
      last_count[idx] <= cnt_q;
      last_time[idx]  <= now_q;
    end
  end

  // Wrap correction against the channel span
  assign span_s    = {3'b0, span_q[ch_q]};
  assign half_s    = span_s >>> 1;
  assign neg_delta = -delta;
  assign ppr_eff   = (ppr_q[ch_q] == '0) ? esm_pkg::PPR_W'(1) : ppr_q[ch_q];

  // Restoring divide: one quotient bit per step
  assign trial      = {rem, low_bits[esm_pkg::QUOT_W-1]};
  assign trial_diff = trial - {1'b0, den};
  assign qbit       = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.load_delta) begin
      dt    <= dt_full[DT_W-1:0];
      delta <= {{2{raw_delta[esm_pkg::CNT_W-1]}}, raw_delta};
    end
    if (cmd.wrap_hi && span_s != '0 && delta > half_s) begin
      delta <= delta - span_s;
    end
    if (cmd.wrap_lo && span_s != '0 && delta < -half_s) begin
      delta <= delta + span_s;
    end
    if (cmd.take_mag) begin
      neg <= delta[esm_pkg::DELTA_W-1];
      mag <= delta[esm_pkg::DELTA_W-1] ? neg_delta[esm_pkg::MAG_W-1:0]
                                       : delta[esm_pkg::MAG_W-1:0];
      den <= DEN_W'(dt) * DEN_W'(ppr_eff);
    end
    if (cmd.mult) begin
      num <= {{esm_pkg::RPM_SCALE_W{1'b0}}, mag}
           * esm_pkg::NUM_W'(esm_pkg::RPM_SCALE);
    end
    if (cmd.div_init) begin
      // Quotient beyond 32 bits when the high part already reaches the divisor
      sat      <= (num[esm_pkg::NUM_W-1:esm_pkg::PRE_SHIFT] >= HI_W'(den));
      rem      <= num[esm_pkg::PRE_SHIFT+DEN_W-1:esm_pkg::PRE_SHIFT];
      low_bits <= {num[esm_pkg::PRE_SHIFT-1:0], {esm_pkg::FRAC_SHIFT{1'b0}}};
      quot     <= '0;
      step_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem      <= qbit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_bits <= {low_bits[esm_pkg::QUOT_W-2:0], 1'b0};
      quot     <= {quot[esm_pkg::QUOT_W-2:0], qbit};
      step_cnt <= step_cnt + esm_pkg::STEP_W'(1);
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
  end

  // Saturate, apply direction and sign
  assign dir_sel = dir_q[ch_q];

  always_comb begin
    mag_fin = (sat || quot > esm_pkg::SPEED_SAT_MAG) ? esm_pkg::SPEED_SAT_MAG : quot;
    neg_fin = neg ^ dir_sel[1];
    if (dir_sel == '0) begin
      mag_fin = '0;
    end
    if (neg_fin) begin
      speed_val = -mag_fin;
    end else if (mag_fin > esm_pkg::SPEED_MAX_POS) begin
      speed_val = esm_pkg::SPEED_MAX_POS;
    end else begin
      speed_val = mag_fin;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= res_status;
      if (res_status == esm_pkg::ST_SPEED) begin
        speed_rpm   <= speed_val;
        interval_ms <= esm_pkg::IVL_W'(dt);
      end else begin
        speed_rpm   <= '0;
        interval_ms <= '0;
      end
    end
  end

  a_base_set: assert property (@(posedge clk) disable iff (rst)
    cmd.store_base |=> base_valid[$past(idx)])
    else $error("baseline not marked valid after store");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take_mag |=> (mag <= esm_pkg::SPEED_SAT_MAG))
    else $error("wrap-corrected delta magnitude exceeds 2^31");

  a_no_speed_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && res_status != esm_pkg::ST_SPEED)
      |=> (speed_rpm == '0 && interval_ms == '0))
    else $error("speed or interval nonzero on a result without speed");

endmodule

`default_nettype wire

>>> rtl/encoder_speed_measure_unit.sv
// ----------------------------------------------------------------------------
// encoder_speed_measure_unit
// Measure requests that produce a speed pass through wrap correction,
//   scaling and the bit-serial divider before the result is loaded.
// Other requests (baseline, out of range, bad channel or opcode) skip to the finish state.
// The result is loaded into the output register once that register is free,
//   and a new request is accepted while it waits to be taken.
// Synchronous reset restores the configuration defaults and clears all
//   baselines and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_measure_unit #(
  parameter int NUM_CHANNELS    = esm_pkg::NUM_CHANNELS_DEF,
  parameter int MIN_INTERVAL_MS = esm_pkg::MIN_INTERVAL_DEF,
  parameter int MAX_INTERVAL_MS = esm_pkg::MAX_INTERVAL_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  esm_in_if.sink     item,
  esm_out_if.source  result,
  esm_cfg_if.sink    cfg
);

  esm_pkg::esm_cmd_t  cmd;
  esm_pkg::esm_stat_t stat;
  logic               cfg_we;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  esm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  esm_datapath #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .MIN_INTERVAL_MS (MIN_INTERVAL_MS),
    .MAX_INTERVAL_MS (MAX_INTERVAL_MS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .opcode        (item.opcode),
    .channel       (item.channel),
    .encoder_count (item.encoder_count),
    .now_ms        (item.now_ms),
    .status        (result.status),
    .speed_rpm     (result.speed_rpm),
    .interval_ms   (result.interval_ms),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire

>>> tb/encoder_speed_measure_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_speed_measure_unit_tb
// Self-checking bench for the per-channel encoder speed meter. A scoreboard
// class mirrors the configuration registers and the per-channel baselines,
// predicts status, speed and interval for each accepted request, and checks
// every result in order. Directed requests cover the interval window edges,
// wrap correction, saturation, the direction settings and rejected channels;
// random phases then reprogram all registers and stream measure sequences
// with random gaps on both sides.
// ----------------------------------------------------------------------------

typedef struct {
  logic [esm_pkg::STATUS_W-1:0]       status;
  logic signed [esm_pkg::SPEED_W-1:0] speed;
  logic [esm_pkg::IVL_W-1:0]          interval;
} speed_result_t;

class rpm_scoreboard;
  logic [esm_pkg::ACT_W-1:0]  active;
  logic [esm_pkg::PPR_W-1:0]  ppr[2];
  logic [esm_pkg::SPAN_W-1:0] span[2];
  logic [esm_pkg::DIR_W-1:0]  dir[2];
  logic [esm_pkg::CNT_W-1:0]  base_count[2];
  logic [esm_pkg::TIME_W-1:0] base_time[2];
  bit                         base_valid[2];
  speed_result_t              expected_speeds[$];
  int                         fail_count;

  function new();
    active = esm_pkg::ACTIVE_RST;
    for (int c = 0; c < 2; c++) begin
      ppr[c]        = esm_pkg::PPR_RST;
      span[c]       = esm_pkg::SPAN_RST;
      dir[c]        = esm_pkg::DIR_RST;
      base_count[c] = '0;
      base_time[c]  = '0;
      base_valid[c] = 1'b0;
    end
    fail_count = 0;
  endfunction

  function int pending();
    return expected_speeds.size();
  endfunction

  // Mirror one register write
  function void write_reg(logic [esm_pkg::CFG_IDX_W-1:0] idx,
                          logic [esm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      esm_pkg::REG_ACTIVE:   active  = data[esm_pkg::ACT_W-1:0];
      esm_pkg::REG_PPR_CH0:  ppr[0]  = data[esm_pkg::PPR_W-1:0];
      esm_pkg::REG_PPR_CH1:  ppr[1]  = data[esm_pkg::PPR_W-1:0];
      esm_pkg::REG_SPAN_CH0: span[0] = data[esm_pkg::SPAN_W-1:0];
      esm_pkg::REG_SPAN_CH1: span[1] = data[esm_pkg::SPAN_W-1:0];
      esm_pkg::REG_DIR_CH0:  dir[0]  = data[esm_pkg::DIR_W-1:0];
      esm_pkg::REG_DIR_CH1:  dir[1]  = data[esm_pkg::DIR_W-1:0];
      default: ;
    endcase
  endfunction

  // Predict the result of one accepted request and queue it
  function void note_request(logic [esm_pkg::OP_W-1:0] op, logic ch,
                             logic [esm_pkg::CNT_W-1:0] cnt,
                             logic [esm_pkg::TIME_W-1:0] stamp);
    speed_result_t              r;
    logic [esm_pkg::TIME_W-1:0] dt;
    logic [esm_pkg::CNT_W-1:0]  raw;
    longint                     delta, sp, half, val;
    longint unsigned            den, pprv, mag, num, q, rem;
    bit                         neg;
    r.status   = esm_pkg::ST_BAD;
    r.speed    = '0;
    r.interval = '0;
    if ({1'b0, ch} >= active || op == esm_pkg::OP_RESERVED) begin
      r.status = esm_pkg::ST_BAD;
    end else if (op == esm_pkg::OP_INVALIDATE) begin
      base_valid[ch] = 1'b0;
      r.status = esm_pkg::ST_BASELINE;
    end else if (op == esm_pkg::OP_RESYNC || !base_valid[ch]) begin
      base_count[ch] = cnt;
      base_time[ch]  = stamp;
      base_valid[ch] = 1'b1;
      r.status = esm_pkg::ST_BASELINE;
    end else begin
      dt = stamp - base_time[ch];
      if (dt < esm_pkg::MIN_INTERVAL_DEF || dt > esm_pkg::MAX_INTERVAL_DEF) begin
        base_count[ch] = cnt;
        base_time[ch]  = stamp;
        r.status = esm_pkg::ST_RANGE;
      end else begin
        // Signed delta, then fold it back into half a span either way
        raw   = cnt - base_count[ch];
        delta = longint'($signed(raw));
        sp    = longint'(span[ch]);
        if (sp > 0) begin
          half = sp / 2;
          if (delta > half) delta = delta - sp;
          if (delta < -half) delta = delta + sp;
        end
        base_count[ch] = cnt;
        base_time[ch]  = stamp;
        // Zero ppr counts as one raw Q16.8 unit
        pprv = (ppr[ch] == '0) ? 64'd1 : 64'(ppr[ch]);
        den  = 64'(dt);
        den  = den * pprv;
        neg  = delta < 0;
        mag  = neg ? -delta : delta;
        num  = mag * esm_pkg::RPM_SCALE;
        q    = num / den;
        rem  = num % den;
        if (q >= esm_pkg::SPEED_SAT_MAG) begin
          mag = 64'(esm_pkg::SPEED_SAT_MAG);
        end else begin
          mag = (q << esm_pkg::FRAC_SHIFT) + ((rem << esm_pkg::FRAC_SHIFT) / den);
          if (mag > esm_pkg::SPEED_SAT_MAG) mag = 64'(esm_pkg::SPEED_SAT_MAG);
        end
        // Direction 0 zeroes the speed; both negative codes flip the sign
        if (dir[ch] == '0) mag = 0;
        else if (dir[ch][1]) neg = !neg;
        val = mag;
        if (neg) val = -val;
        else if (mag > esm_pkg::SPEED_MAX_POS) val = longint'(esm_pkg::SPEED_MAX_POS);
        r.status   = esm_pkg::ST_SPEED;
        r.speed    = val[esm_pkg::SPEED_W-1:0];
        r.interval = dt[esm_pkg::IVL_W-1:0];
      end
    end
    expected_speeds.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Compare one accepted result against the oldest prediction
  task check_result(logic [esm_pkg::STATUS_W-1:0] status,
                    logic signed [esm_pkg::SPEED_W-1:0] speed,
                    logic [esm_pkg::IVL_W-1:0] interval);
    speed_result_t w;
    if (expected_speeds.size() == 0) begin
      report_mismatch($sformatf("result with no request pending (status %0d)", status));
    end else begin
      w = expected_speeds.pop_front();
      if (status !== w.status)
        report_mismatch($sformatf("status got %0d want %0d", status, w.status));
      if (speed !== w.speed)
        report_mismatch($sformatf("speed_rpm got %0d want %0d", speed, w.speed));
      if (interval !== w.interval)
        report_mismatch($sformatf("interval_ms got %0d want %0d", interval, w.interval));
    end
  endtask
endclass

module encoder_speed_measure_unit_tb;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int LONG_HOLD       = 400;
  localparam int TAIL_CYCLES     = 60;
  localparam int STALL_LIMIT     = 3000;

  logic clk;
  logic rst;

  esm_in_if  item_if();
  esm_out_if result_if();
  esm_cfg_if cfg_if();

  encoder_speed_measure_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  rpm_scoreboard sb = new();

  bit send_burst;
  bit take_burst;
  bit hold_results;

  logic [esm_pkg::CNT_W-1:0]  trk_count[2];
  logic [esm_pkg::TIME_W-1:0] trk_time[2];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until taken
  task send_request(logic [esm_pkg::OP_W-1:0] op, logic ch,
                    logic [esm_pkg::CNT_W-1:0] cnt,
                    logic [esm_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid         <= 1'b1;
    item_if.opcode        <= op;
    item_if.channel       <= ch;
    item_if.encoder_count <= cnt;
    item_if.now_ms        <= stamp;
    do @(posedge clk); while (!item_if.ready);
    sb.note_request(op, ch, cnt, stamp);
  endtask

  // Write one register; the caller drops valid after the last write
  task write_reg(logic [esm_pkg::CFG_IDX_W-1:0] idx,
                 logic [esm_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  // Drop the request line and drain every pending result
  task settle();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [esm_pkg::PPR_W-1:0] pick_ppr();
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r    = $urandom();
    if (pick < 40)
      return esm_pkg::PPR_W'(($urandom_range(16, 4096) << 8) + $urandom_range(0, 255));
    else if (pick < 50) return '0;
    else if (pick < 60) return esm_pkg::PPR_W'(1);
    else if (pick < 70) return '1;
    else return r[esm_pkg::PPR_W-1:0];
  endfunction

  function logic [esm_pkg::SPAN_W-1:0] pick_span();
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r    = $urandom();
    if (pick < 25) return esm_pkg::SPAN_RST;
    else if (pick < 37) return '0;
    else if (pick < 47) return '1;
    else if (pick < 60) return esm_pkg::SPAN_W'($urandom_range(1, 16));
    else if (pick < 75) return esm_pkg::SPAN_W'($urandom_range(256, 1 << 20));
    else return r[esm_pkg::SPAN_W-1:0];
  endfunction

  // Program every register, sometimes with junk above the narrow fields
  task randomize_config();
    int                             pick;
    logic [esm_pkg::ACT_W-1:0]      act;
    logic [esm_pkg::CFG_DATA_W-1:0] junk;
    pick = $urandom_range(0, 99);
    if (pick < 70) act = 2'd2;
    else if (pick < 85) act = 2'd1;
    else if (pick < 93) act = 2'd3;
    else act = 2'd0;
    junk = ($urandom_range(0, 2) == 0) ? esm_pkg::CFG_DATA_W'($urandom()) : '0;
    write_reg(esm_pkg::REG_ACTIVE,
              {junk[esm_pkg::CFG_DATA_W-1:esm_pkg::ACT_W], act});
    write_reg(esm_pkg::REG_PPR_CH0,
              {junk[esm_pkg::CFG_DATA_W-1:esm_pkg::PPR_W], pick_ppr()});
    write_reg(esm_pkg::REG_PPR_CH1,
              {junk[esm_pkg::CFG_DATA_W-1:esm_pkg::PPR_W], pick_ppr()});
    write_reg(esm_pkg::REG_SPAN_CH0, pick_span());
    write_reg(esm_pkg::REG_SPAN_CH1, pick_span());
    write_reg(esm_pkg::REG_DIR_CH0,
              {junk[esm_pkg::CFG_DATA_W-1:esm_pkg::DIR_W], 2'($urandom_range(0, 3))});
    write_reg(esm_pkg::REG_DIR_CH1,
              {junk[esm_pkg::CFG_DATA_W-1:esm_pkg::DIR_W], 2'($urandom_range(0, 3))});
    cfg_if.valid <= 1'b0;
  endtask

  // Build a mostly well-formed measure sequence per channel
  task random_request();
    logic [esm_pkg::OP_W-1:0]   op;
    logic                       ch;
    logic [esm_pkg::TIME_W-1:0] dt;
    logic [esm_pkg::CNT_W-1:0]  jump;
    logic [esm_pkg::CNT_W-1:0]  sp;
    int                         pick;
    ch   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 78) op = esm_pkg::OP_MEASURE;
    else if (pick < 88) op = esm_pkg::OP_RESYNC;
    else if (pick < 95) op = esm_pkg::OP_INVALIDATE;
    else op = esm_pkg::OP_RESERVED;

    pick = $urandom_range(0, 99);
    if (pick < 80)
      dt = $urandom_range(esm_pkg::MIN_INTERVAL_DEF, esm_pkg::MAX_INTERVAL_DEF);
    else if (pick < 83) dt = esm_pkg::MIN_INTERVAL_DEF;
    else if (pick < 86) dt = esm_pkg::MAX_INTERVAL_DEF;
    else if (pick < 93) dt = $urandom_range(0, esm_pkg::MIN_INTERVAL_DEF - 1);
    else if (pick < 96) dt = esm_pkg::MAX_INTERVAL_DEF + 1 + $urandom_range(0, 100);
    else dt = $urandom();

    sp   = 32'(sb.span[ch]);
    pick = $urandom_range(0, 99);
    if (pick < 70) jump = $urandom_range(0, 1 << $urandom_range(0, 20));
    else if (pick < 80 && sp != 0) jump = sp - $urandom_range(0, 3);
    else if (pick < 88 && sp != 0) jump = sp / 2 + $urandom_range(0, 2) - 1;
    else jump = $urandom();
    if ($urandom_range(0, 1) == 1) jump = -jump;

    if (op == esm_pkg::OP_MEASURE || op == esm_pkg::OP_RESYNC) begin
      trk_count[ch] = trk_count[ch] + jump;
      trk_time[ch]  = trk_time[ch] + dt;
      send_request(op, ch, trk_count[ch], trk_time[ch]);
    end else begin
      send_request(op, ch, $urandom(), $urandom());
    end
  endtask

  // Take results after random stalls; one long hold-off on request
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, 17);
      if (hold_results) begin
        hold_results = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      sb.check_result(result_if.status, result_if.speed_rpm, result_if.interval_ms);
    end
  end

  // End the run when no channel has moved for too long
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    item_if.valid         <= 1'b0;
    item_if.opcode        <= esm_pkg::OP_MEASURE;
    item_if.channel       <= 1'b0;
    item_if.encoder_count <= '0;
    item_if.now_ms        <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= esm_pkg::REG_ACTIVE;
    cfg_if.data           <= '0;
    send_burst   = 1'b0;
    take_burst   = 1'b0;
    hold_results = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: interval window edges, wrap, saturation at reset settings
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd100, 32'd1000);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd110, 32'd1010);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd111, 32'd3010);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd112, 32'd3019);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd113, 32'd5020);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd65530, 32'd5520);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'd5, 32'd6020);
    send_request(esm_pkg::OP_RESYNC, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'h8000_0000, 32'h0000_0100);
    send_request(esm_pkg::OP_INVALIDATE, 1'b0, 32'h0, 32'h0);
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'h0, 32'd0);
    send_request(esm_pkg::OP_MEASURE, 1'b0, -32'sd3000, 32'd100);
    send_request(esm_pkg::OP_RESERVED, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(esm_pkg::OP_MEASURE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(esm_pkg::OP_MEASURE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0031);
    send_request(esm_pkg::OP_INVALIDATE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(esm_pkg::OP_RESYNC, 1'b1, 32'd1000, 32'd200);

    // Directed: one channel active, reversed feedback, raw ppr, no wrap fix
    settle();
    write_reg(esm_pkg::REG_ACTIVE, 31'd1);
    write_reg(esm_pkg::REG_DIR_CH0, 31'd3);
    write_reg(esm_pkg::REG_PPR_CH0, 31'd0);
    write_reg(esm_pkg::REG_SPAN_CH0, 31'd0);
    cfg_if.valid <= 1'b0;
    send_request(esm_pkg::OP_MEASURE, 1'b1, 32'd1003, 32'd300);
    send_request(esm_pkg::OP_MEASURE, 1'b0, -32'sd2999, 32'd200);

    // Directed: direction minus two, largest ppr and span
    settle();
    write_reg(esm_pkg::REG_DIR_CH0, 31'd2);
    write_reg(esm_pkg::REG_PPR_CH0, 31'hFF_FFFF);
    write_reg(esm_pkg::REG_SPAN_CH0, 31'h7FFF_FFFF);
    cfg_if.valid <= 1'b0;
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'h3FFF_F449, 32'd300);

    // Directed: no channel active, then all active with zero direction on channel 0
    settle();
    write_reg(esm_pkg::REG_ACTIVE, 31'd0);
    cfg_if.valid <= 1'b0;
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'h4000_0000, 32'd350);
    settle();
    write_reg(esm_pkg::REG_ACTIVE, 31'd3);
    write_reg(esm_pkg::REG_DIR_CH0, 31'd0);
    write_reg(esm_pkg::REG_DIR_CH1, 31'd2);
    write_reg(esm_pkg::REG_SPAN_CH1, 31'd1);
    write_reg(esm_pkg::REG_PPR_CH1, 31'h100);
    cfg_if.valid <= 1'b0;
    send_request(esm_pkg::OP_MEASURE, 1'b0, 32'h4000_1000, 32'd400);
    send_request(esm_pkg::OP_MEASURE, 1'b1, 32'd1006, 32'd400);

    // Random phases, each with a fresh register setting
    trk_count[0] = $urandom();
    trk_count[1] = $urandom();
    trk_time[0]  = $urandom();
    trk_time[1]  = 32'hFFFF_F000;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      randomize_config();
      send_burst = (phase == 3) || ($urandom_range(0, 3) == 0);
      take_burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == 30) hold_results = 1'b1;
        if (phase == 6 && n == 50) settle();
        random_request();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
